// ===== hw/rtl/chdc_pkg.sv =====
`timescale 1ns / 1ps

package chdc_pkg;

   localparam int NODES = 64;
   localparam int IDX_W = 6;
   localparam int COORD_W = 20;
   localparam int LEN_W = 16;
   localparam int CSR_IDX_W = 8;

   localparam logic [LEN_W-1:0] LINK_FIRST_RST = 16'd12800;
   localparam logic [LEN_W-1:0] LINK_SECOND_RST = 16'd10240;
   localparam logic [LEN_W-1:0] LINK_THIRD_RST = 16'd7680;
   localparam logic [LEN_W-1:0] LINK_REST_RST = 16'd5120;

   localparam logic [CSR_IDX_W-1:0] REG_LINK_FIRST = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LINK_SECOND = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LINK_THIRD = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LINK_REST = 8'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type y;
      coord_type x;
   } point_type;

   function automatic coord_type sat_coord(input logic signed [COORD_W+1:0] v);
      coord_type r;
      if (v > 22'sd524287) begin
         r = 20'sh7FFFF;
      end else if (v < -22'sd524288) begin
         r = 20'sh80000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/chain_distance_constraint_top.sv =====
`timescale 1ns / 1ps

// Follow-the-leader chain of 64 node positions in signed Q12.8.
// Input words (req_): tuser is the kind. A load word writes one node's
// position and returns nothing. A frame word sets the head to the given
// position and walks the chain, pulling each node onto the line from its
// predecessor at that link's length.
// Result words (rsp_): one per node, head first, tlast on the final node.
// Each node is emitted as soon as it is placed.
// The csr_ port writes the four link lengths; the user must write them
// only at times the block is idle, as the block does not enforce it.
// A frame moves to the emit state, which puts the head in the output
// register once free; each further node passes the 29-step square root
// and 17-step divider, or skips both when it coincides with its anchor.
// The node positions live in one 64-entry memory; a valid bit per entry
// makes every node read as zero after reset, with no clearing pass.
// When the receiver stalls, the walk goes on until the next node is placed
// and then halts until the word in the output register is taken. Reset
// clears the positions, restores the default link lengths and empties the
// output register.
module chain_distance_constraint_top
   import chdc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,  // node_index, pos_x, pos_y, zero fill
   input  logic                 req_tuser,  // kind
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,  // node_index_res, pos_x_res, pos_y_res, zero fill
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_data
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_EMIT = 4'd1;
   localparam logic [3:0] ST_RD   = 4'd2;
   localparam logic [3:0] ST_CALC = 4'd3;
   localparam logic [3:0] ST_SQX  = 4'd4;
   localparam logic [3:0] ST_SQY  = 4'd5;
   localparam logic [3:0] ST_SQRT = 4'd6;
   localparam logic [3:0] ST_NUMX = 4'd7;
   localparam logic [3:0] ST_NUMY = 4'd8;
   localparam logic [3:0] ST_DIV  = 4'd9;
   localparam logic [3:0] ST_FIN  = 4'd10;

   localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);

   logic [3:0] state_ff, state_in;
   logic [LEN_W-1:0] len_first_ff, len_second_ff, len_third_ff, len_rest_ff;

   point_type mem [NODES];
   logic [NODES-1:0] valid_ff;
   point_type rd_data_ff;
   logic rd_valid_ff;

   logic [IDX_W-1:0] node_ff, node_in;
   point_type anchor_ff, anchor_in;
   point_type res_ff, res_in;
   logic signed [20:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [40:0] psq_ff, psq_in;
   logic [57:0] rad_ff, rad_in;
   logic [30:0] srem_ff, srem_in;
   logic [28:0] root_ff, root_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [36:0] numx_ff, numx_in, numy_ff, numy_in;
   logic [45:0] remx_ff, remx_in, remy_ff, remy_in, dvs_ff, dvs_in;
   logic [16:0] qx_ff, qx_in, qy_ff, qy_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   logic req_fire, out_free, wr_en;
   logic [IDX_W-1:0] wr_addr;
   point_type wr_data, pt;
   logic [LEN_W-1:0] link_len;
   logic [20:0] magx, magy;
   logic signed [41:0] sq_a, sq_b;
   logic [41:0] sq_sum;
   logic [32:0] srem_n, strial;
   logic signed [21:0] offx, offy;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   always_comb begin
      case (node_ff)
         6'd1: link_len = len_first_ff;
         6'd2: link_len = len_second_ff;
         6'd3: link_len = len_third_ff;
         default: link_len = len_rest_ff;
      endcase
   end

   assign pt.x = rd_valid_ff ? rd_data_ff.x : '0;
   assign pt.y = rd_valid_ff ? rd_data_ff.y : '0;
   assign magx = dx_ff[20] ? 21'(-dx_ff) : 21'(dx_ff);
   assign magy = dy_ff[20] ? 21'(-dy_ff) : 21'(dy_ff);
   assign sq_a = dx_ff * dx_ff;
   assign sq_b = dy_ff * dy_ff;
   assign sq_sum = {1'b0, psq_ff} + {1'b0, sq_b[40:0]};
   assign srem_n = {srem_ff, rad_ff[57:56]};
   assign strial = {2'b00, root_ff, 2'b01};
   assign offx = dx_ff[20] ? -$signed({5'b0, qx_ff}) : $signed({5'b0, qx_ff});
   assign offy = dy_ff[20] ? -$signed({5'b0, qy_ff}) : $signed({5'b0, qy_ff});

   assign wr_en = (req_fire && req_tuser == KIND_LOAD && {1'b0, req_tdata[5:0]} < 7'(NODES))
                  || (state_ff == ST_EMIT && out_free);
   assign wr_addr = (state_ff == ST_EMIT) ? node_ff : req_tdata[5:0];
   assign wr_data = (state_ff == ST_EMIT) ? res_ff
                    : point_type'({req_tdata[45:26], req_tdata[25:6]});

   always_comb begin
      state_in = state_ff;
      node_in = node_ff;
      anchor_in = anchor_ff;
      res_in = res_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      psq_in = psq_ff;
      rad_in = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      numx_in = numx_ff;
      numy_in = numy_ff;
      remx_in = remx_ff;
      remy_in = remy_ff;
      dvs_in = dvs_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == KIND_FRAME) begin
               res_in = point_type'({req_tdata[45:26], req_tdata[25:6]});
               node_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b00, res_ff.y, res_ff.x, node_ff};
               rsp_last_in = (node_ff == LAST_NODE);
               anchor_in = res_ff;
               if (node_ff == LAST_NODE) begin
                  state_in = ST_IDLE;
               end else begin
                  node_in = node_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            dx_in = {pt.x[19], pt.x} - {anchor_ff.x[19], anchor_ff.x};
            dy_in = {pt.y[19], pt.y} - {anchor_ff.y[19], anchor_ff.y};
            state_in = ST_SQX;
         end
         ST_SQX: begin
            if (dx_ff == '0 && dy_ff == '0) begin
               res_in.x = sat_coord({{2{anchor_ff.x[19]}}, anchor_ff.x}
                                    + $signed({6'b0, link_len}));
               res_in.y = anchor_ff.y;
               state_in = ST_EMIT;
            end else begin
               psq_in = sq_a[40:0];
               state_in = ST_SQY;
            end
         end
         ST_SQY: begin
            rad_in = {sq_sum[41:0], 16'b0};
            srem_in = '0;
            root_in = '0;
            cnt_in = 5'd28;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (srem_n >= strial) begin
               srem_in = 31'(srem_n - strial);
               root_in = {root_ff[27:0], 1'b1};
            end else begin
               srem_in = srem_n[30:0];
               root_in = {root_ff[27:0], 1'b0};
            end
            rad_in = {rad_ff[55:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_NUMX;
            end
         end
         ST_NUMX: begin
            numx_in = magx * link_len;
            state_in = ST_NUMY;
         end
         ST_NUMY: begin
            numy_in = magy * link_len;
            remx_in = {1'b0, numx_ff, 8'b0} + {18'b0, root_ff[28:1]};
            dvs_in = {1'b0, root_ff, 16'b0};
            state_in = ST_DIV;
            cnt_in = 5'd16;
            qx_in = '0;
            qy_in = '0;
         end
         ST_DIV: begin
            if (cnt_ff == 5'd16) begin
               remy_in = {1'b0, numy_ff, 8'b0} + {18'b0, root_ff[28:1]};
               state_in = ST_DIV;
               cnt_in = 5'd17;
            end
            if (cnt_ff != 5'd16) begin
               if (remx_ff >= dvs_ff) begin
                  remx_in = remx_ff - dvs_ff;
                  qx_in = {qx_ff[15:0], 1'b1};
               end else begin
                  qx_in = {qx_ff[15:0], 1'b0};
               end
               if (remy_ff >= dvs_ff) begin
                  remy_in = remy_ff - dvs_ff;
                  qy_in = {qy_ff[15:0], 1'b1};
               end else begin
                  qy_in = {qy_ff[15:0], 1'b0};
               end
               dvs_in = {1'b0, dvs_ff[45:1]};
               cnt_in = (cnt_ff == 5'd17) ? 5'd15 : cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            res_in.x = sat_coord({{2{anchor_ff.x[19]}}, anchor_ff.x} + offx);
            res_in.y = sat_coord({{2{anchor_ff.y[19]}}, anchor_ff.y} + offy);
            state_in = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[node_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_first_ff <= LINK_FIRST_RST;
         len_second_ff <= LINK_SECOND_RST;
         len_third_ff <= LINK_THIRD_RST;
         len_rest_ff <= LINK_REST_RST;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff <= valid_ff[node_ff];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LINK_FIRST: len_first_ff <= csr_data;
               REG_LINK_SECOND: len_second_ff <= csr_data;
               REG_LINK_THIRD: len_third_ff <= csr_data;
               REG_LINK_REST: len_rest_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      anchor_ff <= anchor_in;
      res_ff <= res_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      psq_ff <= psq_in;
      rad_ff <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      numx_ff <= numx_in;
      numy_ff <= numy_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      dvs_ff <= dvs_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_frame_starts_at_head: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == KIND_FRAME |=> state_ff == ST_EMIT && node_ff == '0)
      else $error("frame did not start at the head");

   a_last_on_final_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[5:0] == LAST_NODE)
      else $error("last marked on a node other than the final one");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> root_ff != '0)
      else $error("divider started with a zero length");

endmodule
